### rtl/core/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/drti_pkg.sv
`timescale 1ns / 1ps
package drti_pkg;
  typedef enum logic [1:0] {
    MODE_FLOOR = 2'd0,
    MODE_CEIL  = 2'd1,
    MODE_TRUNC = 2'd2,
    MODE_ROUND = 2'd3
  } mode_t;

  localparam logic [10:0] EXP_MAX  = 11'h7ff;
  localparam logic [10:0] EXP_BIAS = 11'd1023;
  localparam logic [10:0] EXP_INT  = 11'd1075;
  localparam logic [63:0] ONE_BITS = 64'h3ff0000000000000;

  typedef struct packed {
    logic        pass;
    logic        sub_one;
    logic        small_up;
    logic        neg;
    logic [10:0] ex;
    logic [52:0] mant;
    logic [5:0]  nfrac;
    logic [1:0]  mode;
    logic [63:0] bits;
  } dec_t;

  typedef struct packed {
    logic        pass;
    logic        sub_one;
    logic        small_up;
    logic        neg;
    logic [10:0] ex;
    logic [52:0] ip;
    logic [53:0] unit;
    logic        up;
    logic [63:0] bits;
  } rnd_t;
endpackage

### rtl/core/drti_round.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module drti_round (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  drti_pkg::dec_t  in_dec,
  output logic            out_valid,
  output drti_pkg::rnd_t  out_rnd
);
  import drti_pkg::*;

  logic [52:0] low;
  logic [52:0] rem;
  logic [53:0] unit;
  logic        up;

  always_comb begin
    unit = 54'd1 << in_dec.nfrac;
    low  = unit[52:0] - 53'd1;
    rem  = in_dec.mant & low;
    case (mode_t'(in_dec.mode))
      MODE_FLOOR: up = in_dec.neg && (rem != '0);
      MODE_CEIL:  up = !in_dec.neg && (rem != '0);
      MODE_TRUNC: up = 1'b0;
      default:    up = {1'b0, rem} >= (unit >> 1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rnd.pass     <= in_dec.pass;
    out_rnd.sub_one  <= in_dec.sub_one;
    out_rnd.small_up <= in_dec.small_up;
    out_rnd.neg      <= in_dec.neg;
    out_rnd.ex       <= in_dec.ex;
    out_rnd.ip       <= in_dec.mant & ~low;
    out_rnd.unit     <= unit;
    out_rnd.up       <= up;
    out_rnd.bits     <= in_dec.bits;
  end

  `ASSERT_NEXT(a_valid_follows, clk, rst, in_valid, out_valid, "round stage lost a request")
  `ASSERT_NEXT(a_trunc_no_up, clk, rst, in_valid && in_dec.mode == MODE_TRUNC, !out_rnd.up,
               "truncate rounded up")
  `ASSERT_IMPL(a_pass_excl, clk, rst, in_valid && in_dec.pass, !in_dec.sub_one,
               "pass and sub_one both set")
endmodule

### rtl/core/double_round_to_integral_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// start passes the decode register, the round stage register and the result register, in that order, before done
// throughput: one request per cycle, busy is never raised
// stages: decode, mask and round decision, increment and pack
// reset clears the stage valid bits only; the receiver cannot stall
module double_round_to_integral_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [63:0] value_bits,
  output logic        done,
  output logic [63:0] result_bits
);
  import drti_pkg::*;

  logic        v1;
  dec_t        dec;
  logic        v2;
  rnd_t        rnd;
  logic [53:0] sum;
  logic [63:0] res_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    dec.pass    <= (value_bits[62:52] == EXP_MAX) || (value_bits[62:52] >= EXP_INT);
    dec.sub_one <= value_bits[62:52] < EXP_BIAS;
    dec.neg     <= value_bits[63];
    dec.ex      <= value_bits[62:52];
    dec.mant    <= {1'b1, value_bits[51:0]};
    dec.nfrac   <= 6'(EXP_INT - value_bits[62:52]);
    dec.mode    <= kind;
    dec.bits    <= value_bits;
    case (mode_t'(kind))
      MODE_FLOOR: dec.small_up <= value_bits[63] && (value_bits[62:0] != '0);
      MODE_CEIL:  dec.small_up <= !value_bits[63] && (value_bits[62:0] != '0);
      MODE_TRUNC: dec.small_up <= 1'b0;
      default:    dec.small_up <= value_bits[62:52] == EXP_BIAS - 11'd1;
    endcase
  end

  drti_round u_round (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v1),
    .in_dec   (dec),
    .out_valid(v2),
    .out_rnd  (rnd)
  );

  always_comb begin
    sum = {1'b0, rnd.ip} + (rnd.up ? rnd.unit : 54'd0);
    if (rnd.pass) begin
      res_next = rnd.bits;
    end else if (rnd.sub_one) begin
      res_next = rnd.small_up ? ({rnd.neg, 63'd0} | ONE_BITS) : 64'd0;
    end else if (sum[53]) begin
      res_next = {rnd.neg, rnd.ex + 11'd1, sum[52:1]};
    end else begin
      res_next = {rnd.neg, rnd.ex, sum[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
    result_bits <= res_next;
  end

  `ASSERT_NEXT(a_done_follows, clk, rst, v2, done, "result dropped")
  `ASSERT_NEXT(a_nan_pass, clk, rst, v2 && rnd.pass, result_bits == $past(rnd.bits),
               "special value altered")
  `ASSERT_IMPL(a_never_busy, clk, rst, start, !busy, "busy raised")
endmodule
